// ===== hdl/bde_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded deque engine package
// Shared widths, operation and status codes, controller states and the
// command and status bundles that pass between the controller and datapath.
// ----------------------------------------------------------------------------
package bde_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int CMD_W  = 3;
    localparam int TAG_W  = 16;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;
    localparam int CFG_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_BACK  = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } t_dp_ctrl;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/bounded_deque_engine.sv =====
// A beat is captured, then executed with the registered read of the entry store,
// then loaded into the output register once it is free; no new beat is taken
// until the previous one is loaded.
// A finished result waits in the output register while the next beat runs.
// Synchronous reset empties the queue and clears the occupancy limit.
// ----------------------------------------------------------------------------
// Bounded deque engine
// Double-ended queue of tagged entries in a ring store with an occupancy
// limit; each beat performs one push, pop or peek and returns one result.
// ----------------------------------------------------------------------------
module bounded_deque_engine
    import bde_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [TAG_W-1:0]  i_entry_tag,
    input  logic [VAL_W-1:0]  i_entry_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic [VAL_W-1:0]  o_out_value,
    output logic [OCC_W-1:0]  o_occupancy
);

    t_dp_ctrl   dp_ctrl;
    t_dp_status dp_sts;

    bde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_ctrl     (dp_ctrl)
    );

    bde_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_entry_tag   (i_entry_tag),
        .i_entry_value (i_entry_value),
        .i_ctrl        (dp_ctrl),
        .o_sts         (dp_sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_tag     (o_out_tag),
        .o_out_value   (o_out_value),
        .o_occupancy   (o_occupancy)
    );

endmodule

// ===== hdl/bde_ram.sv =====
// ----------------------------------------------------------------------------
// Bounded deque engine RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module bde_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bde_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded deque engine controller
// Sequences each beat through capture, execution and result loading.
// ----------------------------------------------------------------------------
module bde_ctrl
    import bde_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_sts,
    output t_dp_ctrl   o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall     = 1'b0;
                o_ctrl.capture = i_in_valid;
            end
            S_EXEC: begin
                o_ctrl.execute = 1'b1;
            end
            S_LOAD: begin
                o_ctrl.load = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_exec_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> r_state == S_LOAD)
        else $error("Execution was not followed by result loading.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |-> i_sts.out_free)
        else $error("Result loaded while the output register was occupied.");
`endif

endmodule

// ===== hdl/bde_datapath.sv =====
// ----------------------------------------------------------------------------
// Bounded deque engine datapath
// Holds the head index, entry count, limit register, entry store and the
// output register, and performs the operation of the captured beat.
// ----------------------------------------------------------------------------
module bde_datapath
    import bde_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [TAG_W-1:0]    i_entry_tag,
    input  logic [VAL_W-1:0]    i_entry_value,
    input  t_dp_ctrl            i_ctrl,
    output t_dp_status          o_sts,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STAT_W-1:0]   o_status,
    output logic [TAG_W-1:0]    o_out_tag,
    output logic [VAL_W-1:0]    o_out_value,
    output logic [OCC_W-1:0]    o_occupancy
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam int EW   = TAG_W + VAL_W;

    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] cap;
        cap = SW'(CAPACITY);
        if (s >= cap) begin
            return AW'(s - cap);
        end
        return AW'(s);
    endfunction

    logic [CMD_W-1:0] r_cmd;
    logic [TAG_W-1:0] r_tag;
    logic [VAL_W-1:0] r_val;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CFG_W-1:0] r_limit;

    t_status          r_res_status;
    t_status          n_res_status;
    logic             r_res_rd;
    logic             n_res_rd;
    logic             r_res_peek;
    logic             n_res_peek;
    logic [OCC_W-1:0] r_res_occ;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [TAG_W-1:0]  r_out_tag;
    logic [VAL_W-1:0]  r_out_value;
    logic [OCC_W-1:0]  r_out_occ;

    logic [AW-1:0] head_p1;
    logic [AW-1:0] head_m1;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] last_slot;
    logic          is_full;
    logic          is_empty;
    logic          is_front;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    assign head_p1   = wrap(SW'(r_head) + SW'(1));
    assign head_m1   = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign tail_slot = wrap(SW'(r_head) + SW'(r_count));
    assign last_slot = wrap(SW'(r_head) + SW'(r_count) - SW'(1));

    assign is_full = (CMPW'(r_count) >= CMPW'(CAPACITY))
        || ((r_limit != '0) && (CMPW'(r_count) >= CMPW'(r_limit)));
    assign is_empty = (r_count == '0);
    assign is_front = r_cmd inside {CMD_PUSH_FRONT, CMD_POP_FRONT, CMD_PEEK_FRONT};

    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_res_status = ST_OK;
        n_res_rd     = 1'b0;
        n_res_peek   = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = tail_slot;
        ram_raddr    = r_head;
        if (i_ctrl.execute) begin
            case (r_cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (is_full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        if (is_front) begin
                            n_head    = head_m1;
                            ram_waddr = head_m1;
                        end
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                    if (is_empty) begin
                        n_res_status = ST_EMPTY;
                    end else begin
                        ram_re    = 1'b1;
                        n_res_rd  = 1'b1;
                        ram_raddr = is_front ? r_head : last_slot;
                        if (r_cmd inside {CMD_PEEK_FRONT, CMD_PEEK_BACK}) begin
                            n_res_peek = 1'b1;
                        end else begin
                            n_count = r_count - CW'(1);
                            if (is_front) begin
                                n_head = head_p1;
                            end
                        end
                    end
                end
                default: begin
                    n_res_status = ST_OK;
                end
            endcase
        end
    end

    bde_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_tag, r_val}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd <= i_cmd;
            r_tag <= i_entry_tag;
            r_val <= i_entry_value;
        end
        if (i_ctrl.execute) begin
            r_res_status <= n_res_status;
            r_res_rd     <= n_res_rd;
            r_res_peek   <= n_res_peek;
            r_res_occ    <= OCC_W'(n_count);
        end
        if (i_ctrl.load) begin
            r_out_status <= r_res_status;
            r_out_tag    <= r_res_peek ? ram_rdata[VAL_W +: TAG_W] : '0;
            r_out_value  <= r_res_rd ? ram_rdata[VAL_W-1:0] : '0;
            r_out_occ    <= r_res_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_ctrl.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_tag      = r_out_tag;
    assign o_out_value    = r_out_value;
    assign o_occupancy    = r_out_occ;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(CAPACITY))
        else $error("Entry count exceeds the capacity.");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("Store written and read in the same cycle.");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_count == $past(r_count) + CW'(1))
        else $error("Successful push did not increment the count.");
`endif

endmodule

// ===== sim/tb_bounded_deque_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque engine testbench
// Drives push, pop and peek beats through the engine under several occupancy
// limits and idle patterns on both channels, and checks every result beat
// against a cycle-free prediction of the ring-store deque.
// ----------------------------------------------------------------------------
module tb_bounded_deque_engine;
    import bde_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
    localparam int PHASE_BEATS = 125;
    localparam int NUM_PHASES  = 10;

    typedef struct packed {
        t_status           status;
        logic [TAG_W-1:0]  tag;
        logic [VAL_W-1:0]  value;
        logic [OCC_W-1:0]  occ;
    } result_t;

    typedef struct {
        bit                is_cfg;
        logic [CFG_W-1:0]  limit;
        logic [CMD_W-1:0]  cmd;
        logic [TAG_W-1:0]  tag;
        logic [VAL_W-1:0]  value;
        bit                typed;
        result_t           res;
    } script_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_W-1:0]  i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_cmd;
    logic [TAG_W-1:0]  i_entry_tag;
    logic [VAL_W-1:0]  i_entry_value;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [STAT_W-1:0] o_status;
    logic [TAG_W-1:0]  o_out_tag;
    logic [VAL_W-1:0]  o_out_value;
    logic [OCC_W-1:0]  o_occupancy;

    logic [TAG_W-1:0]  deque_tags [DEF_CAPACITY];
    logic [VAL_W-1:0]  deque_values [DEF_CAPACITY];
    logic [5:0]        deque_head;
    logic [OCC_W-1:0]  deque_count;
    logic [CFG_W-1:0]  deque_limit;

    result_t           results_due [$];
    script_row_t       script [$];
    bit                beat_typed;
    result_t           beat_result;
    int                src_idle_pct;
    int                dst_idle_pct;
    int                fault_count;

    bounded_deque_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_entry_tag   (i_entry_tag),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_tag     (o_out_tag),
        .o_out_value   (o_out_value),
        .o_occupancy   (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_bounded_deque_engine: errors");
        $finish;
    end

    task automatic deque_operate(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                                 input logic [VAL_W-1:0] value, output result_t res);
        logic [5:0] slot;
        bit         full;
        bit         front;
        res = '{ST_OK, '0, '0, '0};
        full = (deque_count >= DEF_CAPACITY) ||
               (deque_limit != 0 && deque_count >= deque_limit);
        front = (cmd == CMD_PUSH_FRONT || cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT);
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    if (front) begin
                        deque_head = deque_head - 6'd1;
                        slot = deque_head;
                    end else begin
                        slot = deque_head + deque_count[5:0];
                    end
                    deque_tags[slot] = tag;
                    deque_values[slot] = value;
                    deque_count = deque_count + 7'd1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (deque_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = front ? deque_head : deque_head + 6'(deque_count - 7'd1);
                    res.value = deque_values[slot];
                    if (cmd == CMD_PEEK_FRONT || cmd == CMD_PEEK_BACK) begin
                        res.tag = deque_tags[slot];
                    end else begin
                        if (front) deque_head = deque_head + 6'd1;
                        deque_count = deque_count - 7'd1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.occ = deque_count;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < dst_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        result_t got;
        result_t want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = '{t_status'(o_status), o_out_tag, o_out_value, o_occupancy};
                if (results_due.size() == 0) begin
                    if (fault_count < 10)
                        $display("unexpected result beat: st=%0d tag=%h val=%h occ=%0d",
                                 got.status, got.tag, got.value, got.occ);
                    fault_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.status !== want.status || got.tag !== want.tag ||
                        got.value !== want.value || got.occ !== want.occ) begin
                        if (fault_count < 10)
                            $display("mismatch: want st=%0d tag=%h val=%h occ=%0d, %s%0d %h %h %0d",
                                     want.status, want.tag, want.value, want.occ,
                                     "got ", got.status, got.tag, got.value, got.occ);
                        fault_count++;
                    end
                end
            end
            if (i_cfg_we) deque_limit = i_cfg_wdata;
            if (i_in_valid && !o_in_stall) begin
                deque_operate(i_cmd, i_entry_tag, i_entry_value, want);
                if (beat_typed) want = beat_result;
                results_due.push_back(want);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                             input logic [VAL_W-1:0] value, input bit typed,
                             input result_t res);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_entry_tag   <= tag;
        i_entry_value <= value;
        beat_typed    <= typed;
        beat_result   <= res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic void add_beat(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                                     input logic [VAL_W-1:0] value);
        script.push_back('{0, '0, cmd, tag, value, 0, '{ST_OK, '0, '0, '0}});
    endfunction

    function automatic void add_checked(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                                        input logic [VAL_W-1:0] value, input t_status st,
                                        input logic [TAG_W-1:0] otag,
                                        input logic [VAL_W-1:0] oval,
                                        input logic [OCC_W-1:0] occ);
        script.push_back('{0, '0, cmd, tag, value, 1, '{st, otag, oval, occ}});
    endfunction

    function automatic void add_limit(input logic [CFG_W-1:0] limit);
        script.push_back('{1, limit, '0, '0, '0, 0, '{ST_OK, '0, '0, '0}});
    endfunction

    function automatic logic [VAL_W-1:0] pick_word();
        int sel;
        sel = $urandom_range(15);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return $urandom();
    endfunction

    initial begin : stimulus
        logic [CFG_W-1:0] phase_limit [NUM_PHASES];
        int               push_pct [NUM_PHASES];
        logic [CMD_W-1:0] cmd;
        int               waited;

        phase_limit = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd5, 7'd0, 7'd63, 7'd0, 7'd2, 7'd0};
        push_pct    = '{85, 20, 60, 85, 50, 15, 80, 50, 50, 50};
        phase_limit[7] = 7'($urandom_range(64));

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_cmd         = '0;
        i_entry_tag   = '0;
        i_entry_value = '0;
        i_out_stall   = 1'b0;
        beat_typed    = 1'b0;
        beat_result   = '{ST_OK, '0, '0, '0};
        deque_head    = '0;
        deque_count   = '0;
        deque_limit   = '0;
        fault_count   = 0;
        src_idle_pct  = 25;
        dst_idle_pct  = 76;

        add_checked(CMD_POP_FRONT,  16'h0000, 32'h0, ST_EMPTY, '0, '0, 7'd0);
        add_checked(CMD_POP_BACK,   16'h0000, 32'h0, ST_EMPTY, '0, '0, 7'd0);
        add_checked(CMD_PEEK_FRONT, 16'h0000, 32'h0, ST_EMPTY, '0, '0, 7'd0);
        add_checked(CMD_PEEK_BACK,  16'h0000, 32'h0, ST_EMPTY, '0, '0, 7'd0);
        add_checked(CMD_SPARE_6,    16'h0000, 32'h0, ST_OK, '0, '0, 7'd0);
        add_checked(CMD_SPARE_7,    16'hffff, 32'hffff_ffff, ST_OK, '0, '0, 7'd0);
        add_checked(CMD_PUSH_BACK,  16'hffff, 32'hffff_ffff, ST_OK, '0, '0, 7'd1);
        add_checked(CMD_PUSH_FRONT, 16'h0000, 32'h0, ST_OK, '0, '0, 7'd2);
        add_checked(CMD_PEEK_FRONT, 16'h0000, 32'h0, ST_OK, '0, '0, 7'd2);
        add_checked(CMD_PEEK_BACK,  16'h0000, 32'h0, ST_OK, 16'hffff, 32'hffff_ffff, 7'd2);
        add_beat(CMD_PUSH_FRONT, 16'h1234, 32'hdead_beef);
        add_beat(CMD_POP_BACK,   16'h0000, 32'h0);
        add_beat(CMD_POP_FRONT,  16'h0000, 32'h0);
        add_beat(CMD_POP_FRONT,  16'h0000, 32'h0);
        add_checked(CMD_POP_BACK, 16'h0000, 32'h0, ST_EMPTY, '0, '0, 7'd0);
        add_limit(7'd2);
        add_beat(CMD_PUSH_BACK,  16'h00a5, 32'h0000_5a5a);
        add_beat(CMD_PUSH_BACK,  16'h5a00, 32'ha5a5_0000);
        add_checked(CMD_PUSH_FRONT, 16'h7777, 32'h7777_7777, ST_FULL, '0, '0, 7'd2);
        add_beat(CMD_PEEK_BACK,  16'h0000, 32'h0);
        add_limit(7'd1);
        add_checked(CMD_PUSH_BACK, 16'h1111, 32'h1111_1111, ST_FULL, '0, '0, 7'd2);
        add_beat(CMD_POP_FRONT,  16'h0000, 32'h0);
        add_checked(CMD_PUSH_FRONT, 16'h2222, 32'h2222_2222, ST_FULL, '0, '0, 7'd1);
        add_beat(CMD_POP_BACK,   16'h0000, 32'h0);
        add_limit(7'd64);
        add_beat(CMD_PUSH_FRONT, 16'h8001, 32'h8000_0001);
        add_beat(CMD_POP_FRONT,  16'h0000, 32'h0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[n]) begin
            if (script[n].is_cfg) begin
                wait_idle();
                write_limit(script[n].limit);
            end else begin
                send_beat(script[n].cmd, script[n].tag, script[n].value,
                          script[n].typed, script[n].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 4) begin
                src_idle_pct = 25;
                dst_idle_pct = 76;
            end else if (p < 7) begin
                src_idle_pct = 76;
                dst_idle_pct = 25;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            wait_idle();
            write_limit(phase_limit[p]);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 2 && n == 60) wait_idle();
                if ($urandom_range(99) < 5)
                    cmd = $urandom_range(1) ? CMD_SPARE_7 : CMD_SPARE_6;
                else if ($urandom_range(99) < push_pct[p])
                    cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                else
                    cmd = 3'($urandom_range(CMD_POP_FRONT, CMD_PEEK_BACK));
                send_beat(cmd, TAG_W'(pick_word()), pick_word(), 0, '{ST_OK, '0, '0, '0});
            end
        end

        i_in_valid <= 1'b0;
        waited = 0;
        while (results_due.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (10) @(negedge i_clk);
        if (results_due.size() != 0) begin
            if (fault_count < 10)
                $display("%0d result beats never arrived", results_due.size());
            fault_count += results_due.size();
        end
        if (fault_count == 0) begin
            $display("tb_bounded_deque_engine: clean");
        end else begin
            $display("tb_bounded_deque_engine: errors");
        end
        $finish;
    end

endmodule
